/* rtl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window maximum block
// Default sizes, the configuration register layout, the controller state type
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // The window_size register.
    localparam int              CFG_WIDTH = 7;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 7'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_AGE,
        S_BACK_RD,
        S_BACK_CMP,
        S_APPEND,
        S_FRONT_RD,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take the input beat, clear the stream on restart
        logic rd_back;   // read the back entry instead of the front entry
        logic age;       // drop the front entry if it has left the window
        logic pop;       // drop the back entry
        logic append;    // write the new sample at the back
        logic out_load;  // load the front value into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;  // queue is empty
        logic back_less;   // back entry is strictly smaller than the sample
        logic emit;        // enough samples seen for this one to give a result
        logic out_busy;    // output register holds a beat that is not taken
    } t_stat;

endpackage

/* rtl/swm_if.sv */
// ----------------------------------------------------------------------------
// swm_if: ready/valid channels of the sliding window maximum block
// The input channel carries a sample and a restart flag, the output channel
// carries the window maximum.
// ----------------------------------------------------------------------------
interface swm_in_if #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

/* rtl/swm_datapath.sv */
// ----------------------------------------------------------------------------
// swm_datapath: candidate queue and counters
// Holds the ring of candidate values and positions in a memory with one write
// and one registered read port, the head and count of the ring, the position
// and fill counters, the window register and the output register.
// ----------------------------------------------------------------------------
module swm_datapath #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [swm_pkg::CFG_WIDTH-1:0]      i_cfg_wr_data,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample,
    input  logic                               i_restart,
    input  swm_pkg::t_cmd                      i_cmd,
    output swm_pkg::t_stat                     o_stat,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]     o_window_max
);

    localparam int AW   = $clog2(WINDOW_MAX);       // ring index
    localparam int CW   = $clog2(WINDOW_MAX + 1);   // counts up to WINDOW_MAX
    localparam int PW   = $clog2(WINDOW_MAX) + 1;   // positions, ages up to WINDOW_MAX
    localparam int SUMW = CW + 1;
    localparam int DW   = PW + SAMPLE_WIDTH;

    logic [swm_pkg::CFG_WIDTH-1:0]  r_window;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic [AW-1:0]                  r_head;
    logic [CW-1:0]                  r_count;
    logic [PW-1:0]                  r_pos;
    logic [CW-1:0]                  r_fill;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data;
    logic [DW-1:0]                  r_mem [WINDOW_MAX];
    logic [DW-1:0]                  r_rd_data;

    logic [CW-1:0]                  size;
    logic [AW-1:0]                  rd_addr;
    logic [AW-1:0]                  wr_addr;
    logic [AW-1:0]                  head_inc;
    logic [PW-1:0]                  rd_pos;
    logic signed [SAMPLE_WIDTH-1:0] rd_val;
    logic [PW-1:0]                  age;
    logic                           stale;
    logic                           full;
    logic                           count_zero;

    // Ring slot at an offset from the head; the sum stays below twice the depth.
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [CW-1:0] offs);
        logic [SUMW-1:0] sum;
        sum = SUMW'(head) + SUMW'(offs);
        if (sum >= SUMW'(WINDOW_MAX)) begin
            sum = sum - SUMW'(WINDOW_MAX);
        end
        return sum[AW-1:0];
    endfunction

    assign size = (int'(r_window) > WINDOW_MAX) ? CW'(WINDOW_MAX) : CW'(r_window);

    assign count_zero = (r_count == '0);
    assign full       = (r_count == CW'(WINDOW_MAX));
    assign head_inc   = f_slot(r_head, CW'(1));
    assign wr_addr    = f_slot(r_head, r_count);
    assign rd_addr    = i_cmd.rd_back ? f_slot(r_head, r_count - CW'(1)) : r_head;

    assign rd_pos = r_rd_data[DW-1:SAMPLE_WIDTH];
    assign rd_val = signed'(r_rd_data[SAMPLE_WIDTH-1:0]);
    assign age    = r_pos - rd_pos;
    assign stale  = (age >= PW'(size));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= swm_pkg::CFG_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            priority if (i_cmd.load) begin
                if (i_restart) begin
                    r_head  <= '0;
                    r_count <= '0;
                    r_pos   <= '0;
                    r_fill  <= '0;
                end
            end else if (i_cmd.age) begin
                if (!count_zero && stale) begin
                    r_head  <= head_inc;
                    r_count <= r_count - CW'(1);
                end
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
            end else if (i_cmd.append) begin
                // A full ring overwrites its front entry.
                if (full) begin
                    r_head <= head_inc;
                end else begin
                    r_count <= r_count + CW'(1);
                end
                r_pos <= r_pos + PW'(1);
                if (r_fill != CW'(WINDOW_MAX)) begin
                    r_fill <= r_fill + CW'(1);
                end
            end else begin
                r_pos <= r_pos;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.out_load) begin
            r_out_data <= rd_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[wr_addr] <= {r_pos, r_sample};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_stat.count_zero = count_zero;
    assign o_stat.back_less  = (rd_val < r_sample);
    assign o_stat.emit       = (size != '0) && (r_fill >= size);
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_data;

endmodule

/* rtl/swm_ctrl.sv */
// ----------------------------------------------------------------------------
// swm_ctrl: sequencer of the sliding window maximum block
// Walks each sample through front check, back pops, append and front read,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module swm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  swm_pkg::t_stat i_stat,
    output swm_pkg::t_cmd  o_cmd
);

    swm_pkg::t_state r_state;
    swm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = swm_pkg::S_HEAD;
            end
            swm_pkg::S_HEAD:     n_state = swm_pkg::S_AGE;
            swm_pkg::S_AGE:      n_state = swm_pkg::S_BACK_RD;
            swm_pkg::S_BACK_RD: begin
                n_state = i_stat.count_zero ? swm_pkg::S_APPEND : swm_pkg::S_BACK_CMP;
            end
            swm_pkg::S_BACK_CMP: begin
                n_state = i_stat.back_less ? swm_pkg::S_BACK_RD : swm_pkg::S_APPEND;
            end
            swm_pkg::S_APPEND:   n_state = swm_pkg::S_FRONT_RD;
            swm_pkg::S_FRONT_RD: n_state = swm_pkg::S_OUT;
            swm_pkg::S_OUT: begin
                if (!i_stat.emit || !i_stat.out_busy) n_state = swm_pkg::S_IDLE;
            end
            default:             n_state = swm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            swm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            swm_pkg::S_HEAD:     o_cmd.rd_back = 1'b0;
            swm_pkg::S_AGE:      o_cmd.age     = 1'b1;
            swm_pkg::S_BACK_RD:  o_cmd.rd_back = 1'b1;
            swm_pkg::S_BACK_CMP: o_cmd.pop     = i_stat.back_less;
            swm_pkg::S_APPEND:   o_cmd.append  = 1'b1;
            swm_pkg::S_FRONT_RD: o_cmd.rd_back = 1'b0;
            swm_pkg::S_OUT:      o_cmd.out_load = i_stat.emit && !i_stat.out_busy;
            default:             o_cmd = '0;
        endcase
    end

endmodule

/* rtl/sliding_window_maximum.sv */
// Sequence: an accepted sample passes the head read, the front check, a back read and compare
// for every candidate popped, a last back read (and compare when a candidate is left), the
// append and the front read; then its result beat, if any, is loaded into the output register.
// Flow: a new sample is taken only once the last one is done, including any wait for an earlier
// result beat to be taken; the pops go one by one through the single read port of the queue.
// Reset: synchronous, active low; queue emptied, counters cleared, window_size set to 1.
// ----------------------------------------------------------------------------
// sliding_window_maximum: running maximum over a sliding window of samples
// Keeps a monotonic queue of candidate samples with their positions. Each
// sample drops a front entry that has left the window, pops smaller entries
// from the back and is appended; once a nonzero window has filled, the front
// value is the maximum and is sent out on every sample.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [swm_pkg::CFG_WIDTH-1:0] i_cfg_wr_data,
    swm_in_if.sink                        i_in,
    swm_out_if.source                     o_out
);

    // The controller and the datapath talk only through these two bundles.
    swm_pkg::t_cmd  cmd;
    swm_pkg::t_stat stat;
    logic           in_ready;

    // The sequencer takes one sample at a time and walks it through the
    // queue update. It only offers ready while it is idle.
    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the candidate ring in memory. Positions are kept
    // just wide enough to measure an age of up to WINDOW_MAX, which is the
    // oldest a front entry can be when it is checked, so the comparison
    // agrees with one made on full-width positions.
    swm_datapath #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample      (i_in.sample),
        .i_restart     (i_in.restart),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_window_max  (o_out.window_max)
    );

    assign i_in.ready = in_ready;

`ifndef ASSERT_OFF
    // The output register is only loaded when it is free or being emptied.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !stat.out_busy)
        else $error("output beat overwritten before it was taken");

    // After a sample is accepted the block works on it before taking another.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second sample accepted while one is in progress");

    // Back pops only happen on a non-empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |-> !stat.count_zero)
        else $error("pop from an empty candidate queue");
`endif

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench for sliding_window_maximum
// A short table of directed samples is followed by random sample streams in
// several window settings. Every accepted sample runs through a behavioural
// predictor in this file. Each result beat is compared with the oldest
// predicted window maximum. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH          = swm_pkg::WINDOW_MAX_DEF;
    localparam int SW             = swm_pkg::SAMPLE_WIDTH_DEF;
    localparam int CW             = swm_pkg::CFG_WIDTH;
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_ITEMS   = 900;
    localparam int PEND_DEPTH     = 16;
    // This covers the longest sample, one that pops a full queue from the
    // back, while it is still in flight without giving a result.
    localparam int SETTLE_CYCLES  = 160;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum logic [2:0] {
        RANDOM_SAMPLES,
        NEAR_ZERO,
        FALLING_RAMP,
        RISING_RAMP,
        EXTREME_SAMPLES
    } t_sample_shape;

    // One directed sample. Where typed is set, the expected outcome is given
    // in the row and stands in for the predictor's.
    typedef struct packed {
        bit                    set_window;
        bit [CW-1:0]           window;
        logic signed [SW-1:0]  sample;
        bit                    restart;
        bit                    typed;
        bit                    typed_emit;
        logic signed [SW-1:0]  typed_max;
    } t_directed_row;

    logic clk;
    logic rst_n;
    logic          cfg_wr_en;
    logic [CW-1:0] cfg_wr_data;

    swm_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
    swm_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

    sliding_window_maximum #(
        .WINDOW_MAX   (DEPTH),
        .SAMPLE_WIDTH (SW)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    // Predictor state: a ring of candidate samples with their positions.
    logic signed [SW-1:0] cand_value [DEPTH];
    logic [31:0]          cand_pos   [DEPTH];
    logic [5:0]           cand_head;
    logic [6:0]           cand_count;
    logic [31:0]          pos_next;
    logic [6:0]           fill_seen;
    logic [CW-1:0]        window_setting;

    // Expected window maxima waiting for their beat, oldest at pend_rd.
    logic signed [SW-1:0] expected_maxima [PEND_DEPTH];
    logic [3:0]           pend_wr = '0;
    logic [3:0]           pend_rd = '0;
    int  error_count = 0;
    int  items_sent  = 0;
    int  idle_cycles = 0;
    bit  quiet_tail  = 0;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        // After reset the window is one sample, so each sample is its own maximum.
        '{1'b0, 7'd0,   16'sh7FFF, 1'b1, 1'b1, 1'b1, 16'sh7FFF},
        '{1'b0, 7'd0,   16'sh8000, 1'b0, 1'b1, 1'b1, 16'sh8000},
        '{1'b0, 7'd0,   16'sh0000, 1'b0, 1'b1, 1'b1, 16'sh0000},
        '{1'b0, 7'd0,   16'shFFFF, 1'b0, 1'b1, 1'b1, 16'shFFFF},
        '{1'b0, 7'd0,   16'sh0001, 1'b0, 1'b1, 1'b1, 16'sh0001},
        '{1'b0, 7'd0,   16'sh5555, 1'b1, 1'b1, 1'b1, 16'sh5555},
        '{1'b0, 7'd0,   16'shAAAA, 1'b0, 1'b1, 1'b1, 16'shAAAA},
        // Window of three: nothing until the third sample of the sequence.
        '{1'b1, 7'd3,   16'sh0005, 1'b1, 1'b1, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'sh0003, 1'b0, 1'b1, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'sh0004, 1'b0, 1'b1, 1'b1, 16'sh0005},
        '{1'b0, 7'd0,   16'sh0001, 1'b0, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'sh0001, 1'b0, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'sh0001, 1'b0, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'sh8000, 1'b0, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'sh7FFF, 1'b0, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'sh0009, 1'b1, 1'b1, 1'b0, 16'sh0000},
        // A window of zero queues samples but gives nothing.
        '{1'b1, 7'd0,   16'sh0064, 1'b1, 1'b1, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'sh00C8, 1'b0, 1'b1, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'shFFFB, 1'b0, 1'b1, 1'b0, 16'sh0000},
        // Oversized window, carried on from the stream above.
        '{1'b1, 7'd127, 16'sh0007, 1'b0, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'sh7FFF, 1'b0, 1'b0, 1'b0, 16'sh0000},
        // The window shrinks mid-stream, so stale entries linger at the front.
        '{1'b1, 7'd2,   16'sh0001, 1'b0, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'sh0002, 1'b0, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'sh0003, 1'b0, 1'b0, 1'b0, 16'sh0000},
        '{1'b0, 7'd0,   16'shFFFF, 1'b1, 1'b1, 1'b0, 16'sh0000}
    };

    // Advances the predictor by one sample and returns whether it gives a
    // window maximum.
    function automatic bit predict_window_max(input logic signed [SW-1:0] s,
                                              input logic r,
                                              output logic signed [SW-1:0] wmax);
        logic [6:0]  span;
        logic [31:0] p;
        logic [5:0]  back;
        logic [5:0]  slot;
        span = (window_setting > DEPTH) ? 7'(DEPTH) : window_setting;
        if (r) begin
            cand_head  = '0;
            cand_count = '0;
            pos_next   = '0;
            fill_seen  = '0;
        end
        p = pos_next;
        // Only one stale entry leaves the front per sample.
        if (cand_count != 0 && (p - cand_pos[cand_head]) >= 32'(span)) begin
            cand_head  = cand_head + 6'd1;
            cand_count = cand_count - 7'd1;
        end
        back = cand_head + 6'(cand_count - 7'd1);
        while (cand_count != 0 && cand_value[back] < s) begin
            cand_count = cand_count - 7'd1;
            back       = cand_head + 6'(cand_count - 7'd1);
        end
        if (cand_count >= 7'(DEPTH)) begin
            cand_head  = cand_head + 6'd1;
            cand_count = cand_count - 7'd1;
        end
        slot             = cand_head + cand_count[5:0];
        cand_value[slot] = s;
        cand_pos[slot]   = p;
        cand_count       = cand_count + 7'd1;
        pos_next         = p + 32'd1;
        if (fill_seen < 7'd127)
            fill_seen = fill_seen + 7'd1;
        wmax = cand_value[cand_head];
        return (span != 0) && (fill_seen >= span);
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: ready in random bursts, held high in the quiet tail.
    initial begin : result_ready
        int run;
        out_ch.ready = 1'b0;
        forever begin
            if (quiet_tail) begin
                @(negedge clk);
                out_ch.ready <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                run = $urandom_range(1, 6);
                @(negedge clk);
                out_ch.ready <= 1'b0;
                repeat (run - 1) @(negedge clk);
            end else begin
                run = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
                @(negedge clk);
                out_ch.ready <= 1'b1;
                repeat (run - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin : result_check
        logic signed [SW-1:0] wanted;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pend_wr == pend_rd) begin
                $display("%0t: window_max mismatch, expected no beat, actual %0d",
                         $time, out_ch.window_max);
                error_count++;
            end else begin
                wanted  = expected_maxima[pend_rd];
                pend_rd = pend_rd + 4'd1;
                if (out_ch.window_max !== wanted) begin
                    $display("%0t: window_max mismatch, expected %0d, actual %0d",
                             $time, wanted, out_ch.window_max);
                    error_count++;
                end
            end
        end
    end

    // Ends the run when neither channel has moved a beat for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Offers one sample after an optional gap and books its outcome on acceptance.
    task automatic send_sample(input logic signed [SW-1:0] s, input logic r, input int gap,
                               input bit typed, input bit typed_emit,
                               input logic signed [SW-1:0] typed_max);
        logic signed [SW-1:0] predicted;
        bit                   emits;
        if (gap > 0) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= s;
        in_ch.restart <= r;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        emits = predict_window_max(s, r, predicted);
        if (typed) begin
            emits     = typed_emit;
            predicted = typed_max;
        end
        if (emits) begin
            expected_maxima[pend_wr] = predicted;
            pend_wr = pend_wr + 4'd1;
        end
        items_sent++;
    endtask

    // Stops offering samples and lets the block run dry.
    task automatic drain_stream();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pend_wr != pend_rd) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [CW-1:0] w);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        window_setting = w;
    endtask

    initial begin : stimulus
        logic signed [SW-1:0]  s;
        logic signed [SW-1:0]  level;
        logic [CW-1:0]         w;
        logic                  r;
        t_sample_shape         shape;
        int                    phase;
        int                    phase_len;
        int                    seq_left;
        int                    gap;
        bit                    calm;
        bit                    carry_on;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_ch.valid   = 1'b0;
        in_ch.sample  = '0;
        in_ch.restart = 1'b0;
        cand_head      = '0;
        cand_count     = '0;
        pos_next       = '0;
        fill_seen      = '0;
        window_setting = swm_pkg::CFG_RESET;
        shape          = RANDOM_SAMPLES;
        level          = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_window) begin
                drain_stream();
                write_window(directed_rows[i].window);
            end
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            send_sample(directed_rows[i].sample, directed_rows[i].restart, gap,
                        directed_rows[i].typed, directed_rows[i].typed_emit,
                        directed_rows[i].typed_max);
        end

        // Random phases, each with its own window. Most streams start with a
        // restart and run long enough to fill the window; some phases carry
        // the previous stream on so that a changed window meets a live queue.
        phase = 0;
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            drain_stream();
            case (phase)
                0: w = 7'd64;
                1: w = 7'd127;
                2: w = 7'd0;
                3: w = 7'd1;
                default: begin
                    case ($urandom_range(0, 9))
                        0: w = 7'd0;
                        1: w = 7'd1;
                        2: w = 7'd2;
                        3: w = 7'($urandom_range(3, 16));
                        4: w = 7'd63;
                        5: w = 7'd64;
                        6: w = 7'($urandom_range(65, 127));
                        default: w = 7'($urandom_range(0, 127));
                    endcase
                end
            endcase
            write_window(w);
            calm      = ($urandom_range(0, 3) == 0);
            phase_len = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(20, 140);
            carry_on  = ($urandom_range(0, 3) == 0);
            seq_left  = 0;
            for (int k = 0; k < phase_len && items_sent < DIRECTED_ROWS + RANDOM_ITEMS;
                 k++) begin
                if (items_sent >= DIRECTED_ROWS + RANDOM_ITEMS - 120)
                    quiet_tail = 1'b1;
                if (seq_left == 0) begin
                    seq_left = ($urandom_range(0, 7) == 0) ? 180 : $urandom_range(4, 90);
                    shape    = t_sample_shape'($urandom_range(0, 4));
                    level    = SW'($urandom);
                    r        = !(k == 0 && carry_on);
                end else begin
                    // Now and then a stray restart breaks the sequence.
                    r = ($urandom_range(0, 39) == 0);
                end
                seq_left--;
                case (shape)
                    NEAR_ZERO: begin
                        s = SW'($urandom_range(0, 6));
                        s = s - 16'sd3;
                    end
                    FALLING_RAMP: begin
                        level = level - SW'($urandom_range(0, 3));
                        s     = level;
                    end
                    RISING_RAMP: begin
                        level = level + SW'($urandom_range(0, 3));
                        s     = level;
                    end
                    EXTREME_SAMPLES: begin
                        case ($urandom_range(0, 3))
                            0: s = 16'sh8000;
                            1: s = 16'sh7FFF;
                            2: s = 16'sh0000;
                            default: s = 16'shFFFF;
                        endcase
                    end
                    default: s = SW'($urandom);
                endcase
                gap = (calm || quiet_tail || $urandom_range(0, 3) != 0)
                      ? 0 : $urandom_range(1, 6);
                send_sample(s, r, gap, 1'b0, 1'b0, '0);
            end
            phase++;
        end

        drain_stream();
        if (error_count == 0 && pend_wr == pend_rd) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
